// File: rtl/vbfp_pkg.sv
// ----------------------------------------------------------------------------
// vbfp_pkg
// shared types and constants of the vision block frame parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vbfp_pkg;

	localparam int unsigned BLOCK_LIMIT = 128;

	localparam logic [7:0] MAX_BLOCKS_RST = 8'd128;

	localparam logic [1:0] KIND_VALID     = 2'd0;
	localparam logic [1:0] KIND_CHECK_ERR = 2'd1;
	localparam logic [1:0] KIND_FRAME_END = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] signature;
		logic [15:0] x_pos;
		logic [15:0] y_pos;
		logic [15:0] box_width;
		logic [15:0] box_height;
		logic [15:0] angle;
		logic        color_code;
		logic [7:0]  block_count;
	} result_t;

endpackage

// File: rtl/vbfp_if.sv
// ----------------------------------------------------------------------------
// vbfp_if
// request channels of the parser: raw link bytes in, block results out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vbfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

interface vbfp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] signature;
	logic [15:0] x_pos;
	logic [15:0] y_pos;
	logic [15:0] box_width;
	logic [15:0] box_height;
	logic [15:0] angle;
	logic        color_code;
	logic [7:0]  block_count;

	modport source (
		output valid, output kind, output signature, output x_pos, output y_pos,
		output box_width, output box_height, output angle, output color_code,
		output block_count, input ready
	);
	modport sink (
		input valid, input kind, input signature, input x_pos, input y_pos,
		input box_width, input box_height, input angle, input color_code,
		input block_count, output ready
	);
endinterface

// File: rtl/vbfp_core.sv
// ----------------------------------------------------------------------------
// vbfp_core
// byte pairing, sync hunt, checksum and frame state; one byte per request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vbfp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        byte_in,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	output logic              res_valid,
	output vbfp_pkg::result_t res
);
	import vbfp_pkg::*;

	localparam logic [2:0] PH_HUNT    = 3'd0;
	localparam logic [2:0] PH_DROP    = 3'd1;
	localparam logic [2:0] PH_CHECK   = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_TRAILER = 3'd4;

	localparam logic [15:0] SYNC_WORD    = 16'haa55;
	localparam logic [15:0] SYNC_CC_WORD = 16'haa56;
	localparam logic [15:0] SYNC_SWAPPED = 16'h55aa;
	localparam logic [15:0] NO_WORD      = 16'hffff;

	localparam int unsigned LIMIT_CAP = (BLOCK_LIMIT > 255) ? 255 : BLOCK_LIMIT;
	localparam logic [7:0]  LIMIT_CAP8 = 8'(LIMIT_CAP);

	logic [2:0]  phase_q, phase_d;
	logic        odd_q, odd_d;
	logic [7:0]  low_q, low_d;
	logic [15:0] prev_q, prev_d;
	logic        cc_q, cc_d;
	logic [2:0]  idx_q, idx_d;
	logic [15:0] sum_q, sum_d;
	logic [15:0] exp_q, exp_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [7:0]  max_blocks_q;
	logic [15:0] pw_q [6];

	logic [15:0] word;
	logic [15:0] sum_new;
	logic [15:0] merged [6];
	logic [2:0]  idx_next;
	logic [2:0]  need;
	logic [7:0]  blk_min;
	logic [7:0]  limit;
	logic        is_sync;
	logic        is_cc;
	logic        pw_we;

	function automatic result_t frame_end(input logic [7:0] count);
		result_t r;
		r             = '0;
		r.kind        = KIND_FRAME_END;
		r.block_count = count;
		return r;
	endfunction

	assign word     = {byte_in, low_q};
	assign is_cc    = (word == SYNC_CC_WORD);
	assign is_sync  = (word == SYNC_WORD) || is_cc;
	assign sum_new  = sum_q + word;
	assign idx_next = idx_q + 3'd1;
	assign need     = cc_q ? 3'd6 : 3'd5;
	assign blk_min  = (max_blocks_q == 8'd0) ? 8'd1 : max_blocks_q;
	assign limit    = (blk_min < LIMIT_CAP8) ? blk_min : LIMIT_CAP8;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			merged[i] = (pw_we && idx_q == 3'(i)) ? word : pw_q[i];
		end
	end

	always_comb begin
		phase_d   = phase_q;
		odd_d     = odd_q;
		low_d     = low_q;
		prev_d    = prev_q;
		cc_d      = cc_q;
		idx_d     = idx_q;
		sum_d     = sum_q;
		exp_d     = exp_q;
		cnt_d     = cnt_q;
		pw_we     = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		if (phase_q == PH_DROP) begin
			phase_d = PH_HUNT;
		end else if (!odd_q) begin
			low_d = byte_in;
			odd_d = 1'b1;
		end else begin
			odd_d = 1'b0;
			case (phase_q)
				PH_CHECK: begin
					if (is_sync) begin
						res_valid = 1'b1;
						res       = frame_end(cnt_q);
						cc_d      = is_cc;
						cnt_d     = 8'd0;
					end else if (word == 16'd0) begin
						res_valid = 1'b1;
						res       = frame_end(cnt_q);
						phase_d   = PH_HUNT;
						prev_d    = NO_WORD;
					end else begin
						exp_d   = word;
						sum_d   = 16'd0;
						idx_d   = 3'd0;
						phase_d = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					pw_we = 1'b1;
					sum_d = sum_new;
					idx_d = idx_next;
					if (idx_next >= need) begin
						res_valid = 1'b1;
						if (sum_new == exp_q) begin
							cnt_d    = cnt_q + 8'd1;
							res.kind = KIND_VALID;
						end else begin
							res.kind = KIND_CHECK_ERR;
						end
						res.signature   = merged[0];
						res.x_pos       = merged[1];
						res.y_pos       = merged[2];
						res.box_width   = merged[3];
						res.box_height  = merged[4];
						res.angle       = cc_q ? merged[5] : 16'd0;
						res.color_code  = cc_q;
						res.block_count = cnt_d;
						phase_d         = PH_TRAILER;
					end
				end
				PH_TRAILER: begin
					if (is_sync && cnt_q < limit) begin
						cc_d    = is_cc;
						phase_d = PH_CHECK;
					end else begin
						if (is_sync) begin
							cc_d = is_cc;
						end
						res_valid = 1'b1;
						res       = frame_end(cnt_q);
						phase_d   = PH_HUNT;
						prev_d    = NO_WORD;
					end
				end
				default: begin
					phase_d = PH_HUNT;
					if (word == 16'd0 && prev_q == 16'd0) begin
						res_valid = 1'b1;
						res       = frame_end(8'd0);
						prev_d    = NO_WORD;
					end else if (prev_q == SYNC_WORD && is_sync) begin
						cc_d    = is_cc;
						cnt_d   = 8'd0;
						phase_d = PH_CHECK;
					end else begin
						if (word == SYNC_SWAPPED) begin
							phase_d = PH_DROP;
						end
						prev_d = word;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			odd_q   <= 1'b0;
			low_q   <= 8'd0;
			prev_q  <= NO_WORD;
			cc_q    <= 1'b0;
			idx_q   <= 3'd0;
			sum_q   <= 16'd0;
			exp_q   <= 16'd0;
			cnt_q   <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			odd_q   <= odd_d;
			low_q   <= low_d;
			prev_q  <= prev_d;
			cc_q    <= cc_d;
			idx_q   <= idx_d;
			sum_q   <= sum_d;
			exp_q   <= exp_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_blocks_q <= MAX_BLOCKS_RST;
		end else if (cfg_we) begin
			max_blocks_q <= cfg_wdata;
		end
	end

	// payload words, one lane each
	always_ff @(posedge clk) begin
		for (int i = 0; i < 6; i++) begin
			if (accept && pw_we && idx_q == 3'(i)) begin
				pw_q[i] <= word;
			end
		end
	end

endmodule

// File: rtl/vbfp_out_reg.sv
// ----------------------------------------------------------------------------
// vbfp_out_reg
// result register in front of the output channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vbfp_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  vbfp_pkg::result_t res,
	output logic              slot_free,
	vbfp_result_if.source     blocks
);
	import vbfp_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign slot_free = !valid_q || blocks.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && load) begin
			data_q <= res;
		end
	end

	assign blocks.valid       = valid_q;
	assign blocks.kind        = data_q.kind;
	assign blocks.signature   = data_q.signature;
	assign blocks.x_pos       = data_q.x_pos;
	assign blocks.y_pos       = data_q.y_pos;
	assign blocks.box_width   = data_q.box_width;
	assign blocks.box_height  = data_q.box_height;
	assign blocks.angle       = data_q.angle;
	assign blocks.color_code  = data_q.color_code;
	assign blocks.block_count = data_q.block_count;

endmodule

// File: rtl/vision_block_frame_parser.sv
// ----------------------------------------------------------------------------
// vision_block_frame_parser
// a result is registered: it appears on the output in the cycle after the byte that ends it
// throughput: one byte per cycle unless the output stalls, set by the parser state update
// a byte is taken while the result register is empty or being drained
// reset: asynchronous, hunting for sync, no result pending, limit 128 blocks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vision_block_frame_parser (
	input  logic          clk,
	input  logic          arst_n,
	vbfp_byte_if.sink     link,
	vbfp_result_if.source blocks,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_wdata
);
	import vbfp_pkg::*;

	logic    slot_free;
	logic    accept;
	logic    res_valid;
	result_t res;

	assign link.ready = slot_free;
	assign accept     = link.valid && slot_free;

	vbfp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.byte_in   (link.byte_in),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res_valid (res_valid),
		.res       (res)
	);

	vbfp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && res_valid),
		.res       (res),
		.slot_free (slot_free),
		.blocks    (blocks)
	);

endmodule

// File: tb/vision_block_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// vision_block_frame_parser_tb
// self-checking bench for the camera link block parser: a short directed
// table of link bytes, then random frames built from sync words, checksums
// and payloads mixed with noise, under several block limits; every result is
// compared field by field against a cycle-free model of the parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vision_block_frame_parser_tb;

	import vbfp_pkg::*;

	localparam logic [15:0] START_WORD    = 16'haa55;
	localparam logic [15:0] START_CC_WORD = 16'haa56;
	localparam logic [15:0] SWAPPED_WORD  = 16'h55aa;
	localparam logic [15:0] EMPTY_WORD    = 16'hffff;

	localparam int PHASES      = 5;
	localparam int PHASE_BYTES = 400;

	typedef enum logic [2:0] {
		HUNT_SYNC     = 3'd0,
		SKIP_BYTE     = 3'd1,
		WAIT_CHECKSUM = 3'd2,
		TAKE_PAYLOAD  = 3'd3,
		WAIT_TRAILER  = 3'd4
	} parse_ph_e;

	typedef struct {
		logic [7:0] b;
		bit         typed;
		result_t    want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	vbfp_byte_if   link_ch ();
	vbfp_result_if res_ch ();

	vision_block_frame_parser DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.link      (link_ch),
		.blocks    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// parser model state
	parse_ph_e   p_phase;
	logic        p_odd;
	logic [7:0]  p_low;
	logic [15:0] p_prev;
	logic        p_cc;
	logic [2:0]  p_idx;
	logic [15:0] p_sum;
	logic [15:0] p_chk;
	logic [15:0] p_words [0:5];
	logic [7:0]  p_count;
	logic [7:0]  p_max;

	result_t   want_q [$];
	stim_row_t dir_tab [$];
	logic [7:0] pend [$];

	int  errors;
	int  n_bytes;
	int  n_valid;
	int  n_err;
	int  n_end;
	bit  idle_on;
	bit  hold_req;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("vision_block_frame_parser_tb failed");
		$finish;
	end

	function automatic bit is_start(input logic [15:0] w);
		return (w == START_WORD) || (w == START_CC_WORD);
	endfunction

	function automatic int limit_of(input logic [7:0] m);
		int v;
		v = (m == 8'd0) ? 1 : int'(m);
		return (v < int'(BLOCK_LIMIT)) ? v : int'(BLOCK_LIMIT);
	endfunction

	function automatic result_t frame_end_of(input logic [7:0] c);
		result_t r;
		r = '0;
		r.kind = KIND_FRAME_END;
		r.block_count = c;
		return r;
	endfunction

	task predict_parse(input logic [7:0] b, output bit hit, output result_t r);
		logic [15:0] w;
		hit = 1'b0;
		r = '0;
		if (p_phase == SKIP_BYTE) begin
			p_phase = HUNT_SYNC;
		end else if (!p_odd) begin
			p_low = b;
			p_odd = 1'b1;
		end else begin
			p_odd = 1'b0;
			w = {b, p_low};
			case (p_phase)
				WAIT_CHECKSUM: begin
					if (is_start(w)) begin
						r = frame_end_of(p_count);
						hit = 1'b1;
						p_cc = (w == START_CC_WORD);
						p_count = 8'd0;
					end else if (w == 16'h0000) begin
						r = frame_end_of(p_count);
						hit = 1'b1;
						p_phase = HUNT_SYNC;
						p_prev = EMPTY_WORD;
					end else begin
						p_chk = w;
						p_sum = 16'h0000;
						p_idx = 3'd0;
						p_phase = TAKE_PAYLOAD;
					end
				end
				TAKE_PAYLOAD: begin
					p_words[p_idx] = w;
					p_sum = p_sum + w;
					p_idx = p_idx + 3'd1;
					if (p_idx >= (p_cc ? 3'd6 : 3'd5)) begin
						if (!p_cc)
							p_words[5] = 16'h0000;
						if (p_sum == p_chk) begin
							p_count = p_count + 8'd1;
							r.kind = KIND_VALID;
						end else begin
							r.kind = KIND_CHECK_ERR;
						end
						r.signature = p_words[0];
						r.x_pos = p_words[1];
						r.y_pos = p_words[2];
						r.box_width = p_words[3];
						r.box_height = p_words[4];
						r.angle = p_words[5];
						r.color_code = p_cc;
						r.block_count = p_count;
						hit = 1'b1;
						p_phase = WAIT_TRAILER;
					end
				end
				WAIT_TRAILER: begin
					if (is_start(w)) begin
						p_cc = (w == START_CC_WORD);
						if (int'(p_count) >= limit_of(p_max)) begin
							r = frame_end_of(p_count);
							hit = 1'b1;
							p_phase = HUNT_SYNC;
							p_prev = EMPTY_WORD;
						end else begin
							p_phase = WAIT_CHECKSUM;
						end
					end else begin
						r = frame_end_of(p_count);
						hit = 1'b1;
						p_phase = HUNT_SYNC;
						p_prev = EMPTY_WORD;
					end
				end
				default: begin
					p_phase = HUNT_SYNC;
					if (w == 16'h0000 && p_prev == 16'h0000) begin
						r = frame_end_of(8'd0);
						hit = 1'b1;
						p_prev = EMPTY_WORD;
					end else if (p_prev == START_WORD && is_start(w)) begin
						p_cc = (w == START_CC_WORD);
						p_count = 8'd0;
						p_phase = WAIT_CHECKSUM;
					end else begin
						if (w == SWAPPED_WORD)
							p_phase = SKIP_BYTE;
						p_prev = w;
					end
				end
			endcase
		end
	endtask

	task offer_byte(input logic [7:0] b, input bit typed, input result_t want);
		bit hit;
		result_t r;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			link_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		link_ch.valid <= 1'b1;
		link_ch.byte_in <= b;
		@(posedge clk);
		while (!link_ch.ready)
			@(posedge clk);
		n_bytes++;
		predict_parse(b, hit, r);
		if (typed)
			want_q.push_back(want);
		else if (hit)
			want_q.push_back(r);
	endtask

	task wait_drained();
		link_ch.valid <= 1'b0;
		@(posedge clk);
		while (want_q.size() != 0)
			@(posedge clk);
	endtask

	task set_max_blocks(input logic [7:0] v);
		wait_drained();
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		p_max = v;
	endtask

	task add_row(input logic [7:0] b, input bit typed, input result_t want);
		stim_row_t row;
		row.b = b;
		row.typed = typed;
		row.want = want;
		dir_tab.push_back(row);
	endtask

	task push_word(input logic [15:0] w);
		pend.push_back(w[7:0]);
		pend.push_back(w[15:8]);
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// one random chunk of link traffic, mostly whole frames
	task gen_chunk();
		int sel;
		int nblk;
		int need;
		int k;
		int i;
		bit cc_now;
		bit open;
		logic [15:0] pay [0:5];
		logic [15:0] sum;
		logic [15:0] ck;
		sel = $urandom_range(0, 19);
		if (sel < 15) begin
			cc_now = 1'($urandom_range(0, 1));
			push_word(START_WORD);
			push_word(cc_now ? START_CC_WORD : START_WORD);
			if (limit_of(p_max) <= 8 && $urandom_range(0, 2) == 0)
				nblk = limit_of(p_max) + 1;
			else
				nblk = $urandom_range(1, 4);
			k = 0;
			open = 1'b1;
			while (open && k < nblk) begin
				sel = $urandom_range(0, 19);
				if (sel == 0) begin
					push_word(16'h0000);
					open = 1'b0;
				end else if (sel == 1) begin
					// start word where the checksum belongs
					cc_now = 1'($urandom_range(0, 1));
					push_word(cc_now ? START_CC_WORD : START_WORD);
				end else begin
					need = cc_now ? 6 : 5;
					sum = 16'h0000;
					for (i = 0; i < need; i++) begin
						pay[i] = pick_word();
						sum = sum + pay[i];
					end
					if ($urandom_range(0, 7) == 0)
						ck = sum ^ (16'h0001 << $urandom_range(0, 15));
					else
						ck = sum;
					push_word(ck);
					for (i = 0; i < need; i++)
						push_word(pay[i]);
					if (k == nblk - 1) begin
						case ($urandom_range(0, 2))
							0: push_word(pick_word());
							1: begin
								push_word(START_WORD);
								push_word(16'h0000);
							end
							default: ;
						endcase
					end else begin
						cc_now = 1'($urandom_range(0, 1));
						push_word(cc_now ? START_CC_WORD : START_WORD);
					end
				end
				k++;
			end
		end else if (sel < 17) begin
			repeat ($urandom_range(1, 6))
				pend.push_back(8'($urandom_range(0, 255)));
		end else if (sel == 17) begin
			pend.push_back(8'haa);
			pend.push_back(8'h55);
			pend.push_back(8'($urandom_range(0, 255)));
		end else if (sel == 18) begin
			repeat (4)
				pend.push_back(8'h00);
		end else begin
			// frame cut short inside its payload
			push_word(START_WORD);
			push_word($urandom_range(0, 1) ? START_CC_WORD : START_WORD);
			push_word(pick_word());
			repeat ($urandom_range(0, 4))
				push_word(pick_word());
		end
	endtask

	task check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			errors++;
		end
	endtask

	initial begin : result_sink
		int hold_left;
		int stall_left;
		result_t got;
		result_t want;
		hold_left = 0;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				got = {res_ch.kind, res_ch.signature, res_ch.x_pos, res_ch.y_pos,
					res_ch.box_width, res_ch.box_height, res_ch.angle,
					res_ch.color_code, res_ch.block_count};
				if (want_q.size() == 0) begin
					$error("result with no pending request: kind %0d", got.kind);
					errors++;
				end else begin
					want = want_q.pop_front();
					check_field("kind", 16'(want.kind), 16'(got.kind));
					check_field("signature", want.signature, got.signature);
					check_field("x_pos", want.x_pos, got.x_pos);
					check_field("y_pos", want.y_pos, got.y_pos);
					check_field("box_width", want.box_width, got.box_width);
					check_field("box_height", want.box_height, got.box_height);
					check_field("angle", want.angle, got.angle);
					check_field("color_code", 16'(want.color_code), 16'(got.color_code));
					check_field("block_count", 16'(want.block_count),
						16'(got.block_count));
				end
				if (got.kind == KIND_VALID)
					n_valid++;
				else if (got.kind == KIND_CHECK_ERR)
					n_err++;
				else
					n_end++;
			end
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 199;
				res_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 10) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int ph_i;
		int phase_bytes;
		logic [7:0] plan [0:PHASES-1];
		plan[0] = MAX_BLOCKS_RST;
		plan[1] = 8'd1;
		plan[2] = 8'd0;
		plan[3] = 8'd3;
		plan[4] = 8'd255;

		errors = 0;
		n_bytes = 0;
		n_valid = 0;
		n_err = 0;
		n_end = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 8'd0;
		link_ch.valid <= 1'b0;
		link_ch.byte_in <= 8'd0;

		p_phase = HUNT_SYNC;
		p_odd = 1'b0;
		p_low = 8'd0;
		p_prev = EMPTY_WORD;
		p_cc = 1'b0;
		p_idx = 3'd0;
		p_sum = 16'h0000;
		p_chk = 16'h0000;
		for (int i = 0; i < 6; i++)
			p_words[i] = 16'h0000;
		p_count = 8'd0;
		p_max = MAX_BLOCKS_RST;

		// two zero words while hunting
		add_row(8'h00, 1'b0, '0);
		add_row(8'h00, 1'b0, '0);
		add_row(8'h00, 1'b0, '0);
		add_row(8'h00, 1'b1, frame_end_of(8'd0));
		// reversed start word, next byte dropped
		add_row(8'haa, 1'b0, '0);
		add_row(8'h55, 1'b0, '0);
		add_row(8'hff, 1'b0, '0);
		// color code frame, extreme payload
		add_row(8'h55, 1'b0, '0);
		add_row(8'haa, 1'b0, '0);
		add_row(8'h56, 1'b0, '0);
		add_row(8'haa, 1'b0, '0);
		add_row(8'hfe, 1'b0, '0);
		add_row(8'hff, 1'b0, '0);
		add_row(8'hff, 1'b0, '0);
		add_row(8'hff, 1'b0, '0);
		add_row(8'hff, 1'b0, '0);
		add_row(8'hff, 1'b0, '0);
		for (int i = 0; i < 7; i++)
			add_row(8'h00, 1'b0, '0);
		add_row(8'h00, 1'b1, {KIND_VALID, 16'hffff, 16'hffff, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 1'b1, 8'd1});
		// start word, then zero checksum
		add_row(8'h55, 1'b0, '0);
		add_row(8'haa, 1'b0, '0);
		add_row(8'h00, 1'b0, '0);
		add_row(8'h00, 1'b1, frame_end_of(8'd1));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			offer_byte(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].want);

		for (ph_i = 0; ph_i < PHASES; ph_i++) begin
			if (ph_i > 0)
				set_max_blocks(plan[ph_i]);
			idle_on = (ph_i != PHASES - 1);
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				gen_chunk();
				while (pend.size() != 0) begin
					offer_byte(pend.pop_front(), 1'b0, '0);
					phase_bytes++;
					if (ph_i == 1 && phase_bytes == 100)
						hold_req = 1'b1;
					if (ph_i == 2 && phase_bytes == 200)
						wait_drained();
				end
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("covered %0d link bytes under %0d block limits, with a long output hold",
			n_bytes, PHASES);
		$display("results seen: %0d valid blocks, %0d checksum errors, %0d frame ends",
			n_valid, n_err, n_end);
		if (errors == 0)
			$display("vision_block_frame_parser_tb passed");
		else
			$display("vision_block_frame_parser_tb failed");
		$finish;
	end

endmodule
